FILE: rtl/tks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

	localparam int MAX_KEEP = 16;
	// one end-of-set item can emit at most this many results
	localparam int RES_CAP  = (MAX_KEEP < 16) ? MAX_KEEP : 16;

	localparam int ID_W     = 32;
	localparam int TAG_W    = 16;
	localparam int SCORE_W  = 32;
	localparam int RANK_W   = 4;
	localparam int KEEP_W   = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEEP_COUNT       = 8'd0,
		REG_LARGER_IS_BETTER = 8'd1,
		REG_FILTER_ENABLE    = 8'd2,
		REG_FILTER_TAG       = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                      valid;
		logic [ID_W-1:0]           id;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic upd;   // candidate passes the filter, insert it
		logic load;  // end of set: copy list to drain row, empty the list
		logic pop;   // drain row shifts one place towards the output
		logic lib;   // larger score is better
	} ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/tks_cand_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tks_cand_if;
	logic                               valid;
	logic                               ready;
	logic [tks_pkg::ID_W-1:0]           cand_id;
	logic [tks_pkg::TAG_W-1:0]          cand_tag;
	logic signed [tks_pkg::SCORE_W-1:0] cand_score;
	logic                               end_of_set;

	modport source (output valid, cand_id, cand_tag, cand_score, end_of_set, input ready);
	modport sink   (input valid, cand_id, cand_tag, cand_score, end_of_set, output ready);
endinterface
`default_nettype wire

FILE: rtl/tks_hit_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tks_hit_if;
	logic                               valid;
	logic                               ready;
	logic                               hit_valid;
	logic [tks_pkg::RANK_W-1:0]         hit_rank;
	logic [tks_pkg::ID_W-1:0]           hit_id;
	logic signed [tks_pkg::SCORE_W-1:0] hit_score;
	logic                               hit_last;

	modport source (output valid, hit_valid, hit_rank, hit_id, hit_score, hit_last, input ready);
	modport sink   (input valid, hit_valid, hit_rank, hit_id, hit_score, hit_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/tks_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tks_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tks_pkg::CFG_IDX_W-1:0]     index;
	logic [tks_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tks_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tks_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  tks_pkg::ctrl_t  ctrl,
	input  logic            en,
	input  tks_pkg::entry_t cand,
	input  tks_pkg::entry_t prev_ins,
	input  logic            prev_take,
	input  tks_pkg::entry_t next_drain,
	output tks_pkg::entry_t ins,
	output logic            take,
	output tks_pkg::entry_t drain,
	output tks_pkg::entry_t load_val
);
	import tks_pkg::*;

	entry_t ins_q;
	entry_t drain_q;
	entry_t ins_nx;
	logic   better;

	always_comb begin
		ins       = ins_q;
		ins.valid = ins_q.valid & en;
		better    = ctrl.lib ? (cand.score > ins_q.score) : (cand.score < ins_q.score);
		take      = en & (~ins.valid | better);

		if (!ctrl.upd) begin
			ins_nx = ins_q;
		end else if (prev_take) begin
			// everything from the insertion point down moves one cell along
			ins_nx       = prev_ins;
			ins_nx.valid = prev_ins.valid & en;
		end else if (take) begin
			ins_nx       = cand;
			ins_nx.valid = 1'b1;
		end else begin
			ins_nx = ins;
		end

		load_val       = ins_nx;
		load_val.valid = ins_nx.valid & en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q   <= '0;
			drain_q <= '0;
		end else begin
			if (ctrl.load) begin
				// list moves to the drain row, insertion row starts empty
				ins_q   <= '0;
				drain_q <= load_val;
			end else begin
				ins_q <= ins_nx;
				if (ctrl.pop) begin
					drain_q <= next_drain;
				end
			end
		end
	end

	assign drain = drain_q;
endmodule
`default_nettype wire

FILE: rtl/top_k_score_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming top-K selector.
// cand: one scored candidate per item (id, tag, Q16.16 score, end_of_set).
// cfg:  register writes (index, data), always ready; write only while idle.
// hit:  result items, best first, ties in arrival order; hit_last marks the
//       final one, a lone item with hit_valid 0 reports an empty set.
// A row of MAX_KEEP cells holds the kept list in order. Each item is
// compared against every cell at once and the list shifts one cell down at
// the insertion point, so one candidate is taken every cycle while ready is high.
// On end_of_set the updated list is copied into a second (drain) row of the
// same cells and the insertion row empties; the next query streams in while
// the drain row shifts out one result per cycle while the receiver is ready.
// The first result appears the cycle after the end_of_set item is accepted.
// An end_of_set item waits (ready low) only while results or the empty-set
// item of the previous query are still pending; other items are never stalled.
// If the receiver stalls, the drain row holds its contents.
// Reset empties both rows and loads keep_count 1, all other registers 0.
module top_k_score_selector (
	input  logic        clk,
	input  logic        arst_n,
	tks_cand_if.sink    cand,
	tks_hit_if.source   hit,
	tks_cfg_if.sink     cfg
);
	import tks_pkg::*;

	logic [KEEP_W-1:0] keep_count_q;
	logic              larger_is_better_q;
	logic              filter_enable_q;
	logic [TAG_W-1:0]  filter_tag_q;

	logic [KEEP_W-1:0] k_eff;
	logic              cand_acc;
	logic              hit_acc;
	logic              busy;
	logic              empty_q;
	logic [RANK_W-1:0] rank_q;
	ctrl_t             ctrl;
	entry_t            new_cand;

	logic   [MAX_KEEP-1:0] cell_en;
	logic   [MAX_KEEP-1:0] take;
	entry_t ins        [MAX_KEEP];
	entry_t drain      [MAX_KEEP];
	entry_t drain_next [MAX_KEEP];
	entry_t load_val   [MAX_KEEP];

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q       <= KEEP_W'(1);
			larger_is_better_q <= 1'b0;
			filter_enable_q    <= 1'b0;
			filter_tag_q       <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEEP_COUNT:       keep_count_q       <= cfg.data[KEEP_W-1:0];
				REG_LARGER_IS_BETTER: larger_is_better_q <= cfg.data[0];
				REG_FILTER_ENABLE:    filter_enable_q    <= cfg.data[0];
				REG_FILTER_TAG:       filter_tag_q       <= cfg.data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (keep_count_q == '0) begin
			k_eff = KEEP_W'(1);
		end else if (32'(keep_count_q) > RES_CAP) begin
			k_eff = KEEP_W'(RES_CAP);
		end else begin
			k_eff = keep_count_q;
		end
	end

	// control
	assign busy       = drain[0].valid | empty_q;
	assign cand.ready = ~(busy & cand.end_of_set);
	assign cand_acc   = cand.valid & cand.ready;
	assign hit_acc    = hit.valid & hit.ready;

	always_comb begin
		ctrl.upd  = cand_acc & (~filter_enable_q | (cand.cand_tag == filter_tag_q));
		ctrl.load = cand_acc & cand.end_of_set;
		ctrl.pop  = hit_acc;
		ctrl.lib  = larger_is_better_q;

		new_cand.valid = 1'b1;
		new_cand.id    = cand.cand_id;
		new_cand.score = cand.cand_score;
	end

	// cell row
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		assign cell_en[i] = (32'(i) < 32'(k_eff));

		if (i + 1 < MAX_KEEP) begin : g_nx
			assign drain_next[i] = drain[i+1];
		end else begin : g_end
			assign drain_next[i] = '0;
		end

		if (i == 0) begin : g_head
			tks_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.en         (cell_en[i]),
				.cand       (new_cand),
				.prev_ins   ('0),
				.prev_take  (1'b0),
				.next_drain (drain_next[i]),
				.ins        (ins[i]),
				.take       (take[i]),
				.drain      (drain[i]),
				.load_val   (load_val[i])
			);
		end else begin : g_body
			tks_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.en         (cell_en[i]),
				.cand       (new_cand),
				.prev_ins   (ins[i-1]),
				.prev_take  (take[i-1]),
				.next_drain (drain_next[i]),
				.ins        (ins[i]),
				.take       (take[i]),
				.drain      (drain[i]),
				.load_val   (load_val[i])
			);
		end
	end

	// output sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctrl.load) begin
			empty_q <= ~load_val[0].valid;
			rank_q  <= '0;
		end else if (ctrl.pop) begin
			empty_q <= 1'b0;
			rank_q  <= rank_q + RANK_W'(1);
		end
	end

	assign hit.valid     = busy;
	assign hit.hit_valid = drain[0].valid;
	assign hit.hit_rank  = rank_q;
	assign hit.hit_id    = drain[0].valid ? drain[0].id : '0;
	assign hit.hit_score = drain[0].valid ? drain[0].score : '0;
	assign hit.hit_last  = ~drain_next[0].valid;

`ifndef SYNTHESIS
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> !busy)
		else $error("end of set accepted while results still draining");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		hit_acc && hit.hit_last |=> !hit.valid)
		else $error("results remain after last item");

	a_rank_steps: assert property (@(posedge clk) disable iff (!arst_n)
		hit_acc && !hit.hit_last |=> hit.valid && hit.hit_valid &&
			(hit.hit_rank == $past(rank_q) + RANK_W'(1)))
		else $error("result rank did not advance");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid && !hit.hit_valid |-> hit.hit_last && (hit.hit_rank == '0))
		else $error("empty-set item not alone");
`endif
endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import tks_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYC  = 8;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic                      hv;
		logic [RANK_W-1:0]         rank;
		logic [ID_W-1:0]           id;
		logic signed [SCORE_W-1:0] score;
		logic                      last;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n;

	tks_cand_if cand_ch ();
	tks_hit_if  hit_ch ();
	tks_cfg_if  cfg_ch ();

	top_k_score_selector uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.hit    (hit_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	int          errors = 0;
	int unsigned cycle_cnt = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	bit          tag_bias = 1'b0;
	logic [TAG_W-1:0] tag_want = '0;

	// shadow of the register file and the ranked list
	logic [KEEP_W-1:0]         keep_reg = 5'd1;
	logic                      lib_reg = 1'b0;
	logic                      filt_en_reg = 1'b0;
	logic [TAG_W-1:0]          filt_tag_reg = '0;
	logic [ID_W-1:0]           kept_id [MAX_KEEP];
	logic signed [SCORE_W-1:0] kept_score [MAX_KEEP];
	int                        kept_n = 0;
	hit_t                      hits_due [$];

	function automatic int active_k();
		int k;
		k = int'(keep_reg);
		if (k == 0) k = 1;
		if (k > RES_CAP) k = RES_CAP;
		return k;
	endfunction

	function automatic bit outranks(logic signed [SCORE_W-1:0] a, logic signed [SCORE_W-1:0] b);
		return lib_reg ? (a > b) : (a < b);
	endfunction

	function automatic void insert_ranked(logic [ID_W-1:0] id, logic signed [SCORE_W-1:0] score);
		int k;
		int pos;
		int n_new;
		k = active_k();
		pos = 0;
		// a lowered K trims the worst entries first
		if (kept_n > k) kept_n = k;
		while (pos < kept_n && !outranks(score, kept_score[pos])) pos++;
		n_new = (kept_n < k) ? kept_n + 1 : k;
		if (pos >= n_new) return;
		for (int i = n_new - 1; i > pos; i--) begin
			kept_id[i]    = kept_id[i-1];
			kept_score[i] = kept_score[i-1];
		end
		kept_id[pos]    = id;
		kept_score[pos] = score;
		kept_n          = n_new;
	endfunction

	function automatic void queue_hit(hit_t h);
		hits_due.insert(hits_due.size(), h);
	endfunction

	function automatic void predict_cand(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
			logic signed [SCORE_W-1:0] score, logic last);
		hit_t h;
		int   n;
		if (!filt_en_reg || tag == filt_tag_reg) insert_ranked(id, score);
		if (!last) return;
		n = (kept_n < active_k()) ? kept_n : active_k();
		if (n == 0) begin
			h = '0;
			h.last = 1'b1;
			queue_hit(h);
		end else begin
			for (int i = 0; i < n; i++) begin
				h.hv    = 1'b1;
				h.rank  = i[RANK_W-1:0];
				h.id    = kept_id[i];
				h.score = kept_score[i];
				h.last  = (i == n - 1);
				queue_hit(h);
			end
		end
		kept_n = 0;
	endfunction

	always @(posedge clk) begin : scoreboard
		hit_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_KEEP_COUNT:       keep_reg     = cfg_ch.data[KEEP_W-1:0];
					REG_LARGER_IS_BETTER: lib_reg      = cfg_ch.data[0];
					REG_FILTER_ENABLE:    filt_en_reg  = cfg_ch.data[0];
					REG_FILTER_TAG:       filt_tag_reg = cfg_ch.data[TAG_W-1:0];
					default: ;
				endcase
			end
			if (cand_ch.valid && cand_ch.ready)
				predict_cand(cand_ch.cand_id, cand_ch.cand_tag, cand_ch.cand_score,
					cand_ch.end_of_set);
			if (hit_ch.valid && hit_ch.ready) begin
				if (hits_due.size() == 0) begin
					$error("unexpected hit: id %0h score %0h", hit_ch.hit_id, hit_ch.hit_score);
					errors++;
				end else begin
					want = hits_due.pop_front();
					if (hit_ch.hit_valid !== want.hv) begin
						$error("hit_valid: expected %0d, got %0d", want.hv, hit_ch.hit_valid);
						errors++;
					end
					if (hit_ch.hit_rank !== want.rank) begin
						$error("hit_rank: expected %0d, got %0d", want.rank, hit_ch.hit_rank);
						errors++;
					end
					if (hit_ch.hit_id !== want.id) begin
						$error("hit_id: expected %0h, got %0h", want.id, hit_ch.hit_id);
						errors++;
					end
					if (hit_ch.hit_score !== want.score) begin
						$error("hit_score: expected %0h, got %0h", want.score, hit_ch.hit_score);
						errors++;
					end
					if (hit_ch.hit_last !== want.last) begin
						$error("hit_last: expected %0d, got %0d", want.last, hit_ch.hit_last);
						errors++;
					end
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			hit_ch.ready <= 1'b0;
		end else begin
			hit_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// valid stays high between back-to-back items; the caller lowers it
	task automatic send_cand(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
			logic signed [SCORE_W-1:0] score, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			cand_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cand_ch.valid      <= 1'b1;
		cand_ch.cand_id    <= id;
		cand_ch.cand_tag   <= tag;
		cand_ch.cand_score <= score;
		cand_ch.end_of_set <= last;
		do @(posedge clk); while (!(cand_ch.valid && cand_ch.ready));
	endtask

	task automatic drain_hits();
		cand_ch.valid <= 1'b0;
		do @(posedge clk); while (hits_due.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [TAG_W-1:0] pick_tag();
		if (tag_bias && $urandom_range(99) < 70) return tag_want;
		return TAG_W'($urandom);
	endfunction

	function automatic logic signed [SCORE_W-1:0] pick_score();
		case ($urandom_range(9))
			0:       return {1'b0, {(SCORE_W-1){1'b1}}};
			1:       return {1'b1, {(SCORE_W-1){1'b0}}};
			2, 3, 4: return SCORE_W'((int'($urandom_range(6)) - 3) <<< 16); // ties
			default: return SCORE_W'($urandom);
		endcase
	endfunction

	task automatic send_query(int qlen);
		for (int i = 0; i < qlen; i++)
			send_cand($urandom, pick_tag(), pick_score(), i == qlen - 1);
	endtask

	task automatic test_defaults();
		// K 1, distance mode straight out of reset
		send_cand(32'h0, 16'h0, 32'sh7FFF_FFFF, 1'b0);
		send_cand(32'hFFFF_FFFF, 16'hFFFF, 32'sh8000_0000, 1'b0);
		send_cand(32'h1, 16'h1234, 32'sh0, 1'b1);
		drain_hits();
	endtask

	task automatic test_ties();
		write_reg(REG_KEEP_COUNT, 16'd3);
		write_reg(REG_LARGER_IS_BETTER, 16'd1);
		// equal scores keep arrival order; an equal one cannot displace when full
		for (int i = 1; i <= 4; i++)
			send_cand(i, 16'h0, 32'sh0005_0000, 1'b0);
		send_cand(32'h5, 16'h0, 32'sh0005_0001, 1'b1);
		drain_hits();
	endtask

	task automatic test_filter();
		write_reg(REG_KEEP_COUNT, 16'd2);
		write_reg(REG_FILTER_ENABLE, 16'd1);
		write_reg(REG_FILTER_TAG, 16'hFFFF);
		// everything filtered out: lone empty-set item
		send_cand(32'hA1, 16'h0000, 32'sh1, 1'b0);
		send_cand(32'hA2, 16'hFFFE, 32'sh2, 1'b1);
		send_cand(32'hB1, 16'hFFFF, 32'sh3, 1'b0);
		send_cand(32'hB2, 16'h7FFF, -32'sh1, 1'b0);
		send_cand(32'hB3, 16'hFFFF, 32'sh7FFF_FFFF, 1'b1);
		drain_hits();
		write_reg(REG_FILTER_TAG, 16'h0000);
		send_cand(32'hC1, 16'h0000, -32'sh7, 1'b1);
		drain_hits();
		write_reg(REG_FILTER_ENABLE, 16'd0);
	endtask

	task automatic test_keep_zero();
		write_reg(REG_KEEP_COUNT, 16'd0);
		send_cand(32'hD1, 16'h1, 32'sh10, 1'b0);
		send_cand(32'hD2, 16'h2, 32'sh08, 1'b1);
		drain_hits();
	endtask

	task automatic test_shrink();
		write_reg(REG_KEEP_COUNT, 16'd4);
		write_reg(REG_LARGER_IS_BETTER, 16'd0);
		for (int i = 0; i < 4; i++)
			send_cand(32'hE0 + i, 16'h0, SCORE_W'(i * 100), 1'b0);
		drain_hits();
		// list holds four; the next item first trims it to two
		write_reg(REG_KEEP_COUNT, 16'd2);
		send_cand(32'hE9, 16'h0, 32'sh150, 1'b1);
		drain_hits();
	endtask

	task automatic test_bad_index();
		write_reg(CFG_IDX_W'($urandom_range(REG_FILTER_TAG + 1, {CFG_IDX_W{1'b1}})),
			CFG_DATA_W'($urandom));
		send_cand(32'hF1, 16'h0, 32'sh0, 1'b1);
		drain_hits();
	endtask

	task automatic test_backpressure();
		write_reg(REG_KEEP_COUNT, 16'd16);
		write_reg(REG_LARGER_IS_BETTER, 16'd1);
		send_idle_pct = 0;
		stall_pct     = 0;
		tag_bias      = 1'b0;
		hold_req      = 1'b1;
		// receiver frozen: second end of set must stall the input
		for (int q = 0; q < 4; q++)
			send_query(6);
		drain_hits();
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] keep, logic lib, logic fen,
			logic [TAG_W-1:0] ftag, int idle_pct, int stall, int n_items);
		int sent;
		int qlen;
		write_reg(REG_KEEP_COUNT, keep);
		write_reg(REG_LARGER_IS_BETTER, CFG_DATA_W'(lib));
		write_reg(REG_FILTER_ENABLE, CFG_DATA_W'(fen));
		write_reg(REG_FILTER_TAG, ftag);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		tag_bias      = fen;
		tag_want      = ftag;
		sent = 0;
		while (sent < n_items) begin
			qlen = ($urandom_range(99) < 20) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			if (qlen > n_items - sent) qlen = n_items - sent;
			send_query(qlen);
			sent += qlen;
		end
		drain_hits();
	endtask

	task automatic test_random();
		run_phase(16'd16, 1'b0, 1'b0, 16'h0000, 0, 0, 20);
		run_phase(CFG_DATA_W'($urandom_range(2, 15)), 1'b1, 1'b1, 16'hFFFF, 50, 0, 20);
		// K field reads 31 here and saturates
		run_phase(16'hFFFF, 1'b0, 1'b1, 16'h0000, 0, 50, 22);
		run_phase(16'd1, 1'b1, 1'b0, TAG_W'($urandom), 13, 13, 22);
	endtask

	initial begin
		arst_n             = 1'b0;
		cand_ch.valid      = 1'b0;
		cand_ch.cand_id    = '0;
		cand_ch.cand_tag   = '0;
		cand_ch.cand_score = '0;
		cand_ch.end_of_set = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		hit_ch.ready       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_ties();
		test_filter();
		test_keep_zero();
		test_shrink();
		test_bad_index();
		test_backpressure();
		test_random();

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
